FILE: rtl/c2s_pkg.sv
package c2s_pkg;

    // datapath widths
    localparam int DATA_W      = 64;
    localparam int ANG_W       = 36;
    localparam int LON_W       = 25;
    localparam int LAT_W       = 24;
    localparam int GUARD_TOTAL = 60;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [ANG_W-1:0]  angle_t;

    // vector state handed from cell to cell
    typedef struct packed {
        word_t  a;
        word_t  b;
        angle_t ang;
    } cvec_t;

    // special-case flags carried alongside an item
    typedef struct packed {
        logic zero_xy;
        logic z_pos;
        logic z_neg;
    } flags_t;

    // CORDIC gain in Q30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

    // angles in units of 2^-24 degree
    localparam angle_t ANG_45    = 36'sd754974720;
    localparam angle_t HALF_TURN = 36'sd3019898880;
    localparam angle_t FULL_TURN = 36'sd6039797760;
    localparam angle_t ANG_ROUND = 36'sd128;

    // output limits in units of 2^-16 degree
    localparam angle_t LAT_LIMIT = 36'sd5898240;
    localparam angle_t LON_WRAP  = 36'sd23592960;

    // round(180/pi * 2^24)
    localparam logic [63:0] DEG_SCALE = 64'd961263669;

    // one arctangent series term divided by its odd denominator 2k+1
    function automatic logic [63:0] div_odd(input logic [63:0] num, input int k);
        unique case (k)
            0:       return num;
            1:       return num / 64'd3;
            2:       return num / 64'd5;
            3:       return num / 64'd7;
            4:       return num / 64'd9;
            5:       return num / 64'd11;
            6:       return num / 64'd13;
            7:       return num / 64'd15;
            8:       return num / 64'd17;
            9:       return num / 64'd19;
            10:      return num / 64'd21;
            11:      return num / 64'd23;
            12:      return num / 64'd25;
            13:      return num / 64'd27;
            14:      return num / 64'd29;
            15:      return num / 64'd31;
            16:      return num / 64'd33;
            17:      return num / 64'd35;
            18:      return num / 64'd37;
            19:      return num / 64'd39;
            20:      return num / 64'd41;
            21:      return num / 64'd43;
            22:      return num / 64'd45;
            23:      return num / 64'd47;
            24:      return num / 64'd49;
            25:      return num / 64'd51;
            26:      return num / 64'd53;
            27:      return num / 64'd55;
            28:      return num / 64'd57;
            29:      return num / 64'd59;
            default: return '0;
        endcase
    endfunction

    // floor(atan(2^-idx) in degrees * 2^24), via the Q60 series
    function automatic angle_t stage_angle(input int idx);
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] scaled;
        int          sh;
        acc = '0;
        if (idx == 0)
        begin
            return ANG_45;
        end
        for (int k = 0; k < 30; k++)
        begin
            sh = idx * (2 * k + 1);
            if (sh <= GUARD_TOTAL)
            begin
                term = div_odd(64'd1 << (GUARD_TOTAL - sh), k);
                if (k[0])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        scaled = ((acc >> 28) * DEG_SCALE + (((acc & 64'hFFF_FFFF) * DEG_SCALE) >> 28)) >> 32;
        return scaled[ANG_W-1:0];
    endfunction

endpackage

FILE: rtl/cartesian_to_spherical.sv
// Cartesian to spherical converter, one 3D point per item.
// Input stream (s_*): tdata carries x_coord, y_coord, z_coord, signed integers.
// Output stream (m_*): tdata carries magnitude (rounded length), longitude
// in [0, 360) degrees and latitude in [-90, 90] degrees, both in 1/65536 degree.
// Datapath: two rows of CORDIC vectoring cells, CORDIC_STAGES each (longitude,
// then latitude on the remaining radius), next to a row of COORD_BITS
// square-root cells fed by a sum of squares.
// The longer of the two CORDIC rows and the square-root row sets the delay from
// accept to m_tvalid; with the default parameters the two CORDIC rows set it.
// Throughput: one item per cycle while s_tready is high; each cell stage then takes a new item.
// A two-entry output buffer holds finished items; while it has room the whole
// pipeline advances and s_tready stays high. When the receiver stalls and both
// entries fill, s_tready drops and the pipeline holds until an entry drains.
// Reset (rst_n low, asynchronous) empties the pipeline and the output buffer;
// s_tready is high right after reset.
module cartesian_to_spherical #(
    parameter  int COORD_BITS    = 24,
    parameter  int CORDIC_STAGES = 24,
    localparam int S_DATA_W      = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W      = ((COORD_BITS + c2s_pkg::LON_W + c2s_pkg::LAT_W + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // x_coord, y_coord, z_coord
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // magnitude, longitude, latitude
);

    import c2s_pkg::*;

    localparam int SQ_W      = 2 * COORD_BITS;
    localparam int GUARD     = GUARD_TOTAL - COORD_BITS;
    localparam int ZB_LSH    = (GUARD >= 30) ? GUARD - 30 : 0;
    localparam int ZB_RSH    = (GUARD < 30) ? 30 - GUARD : 0;
    localparam int LON_END   = CORDIC_STAGES + 1;
    localparam int LAT_END   = 2 * CORDIC_STAGES + 1;
    localparam int SQ_END    = COORD_BITS + 2;
    localparam int PRE_FINAL = (LAT_END > SQ_END) ? LAT_END : SQ_END;
    localparam int OUT_W     = COORD_BITS + LON_W + LAT_W;
    localparam logic [1:0] BUF_FULL = 2'd2;

    // input fields
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;
    word_t                        x_w;
    word_t                        y_w;
    word_t                        a_start;
    word_t                        b_start;
    logic signed [COORD_BITS+31:0] zb_prod;
    word_t                        zb_scaled;
    word_t                        zb_d;
    logic signed [SQ_W-1:0]       sq_x_p;
    logic signed [SQ_W-1:0]       sq_y_p;
    logic signed [SQ_W-1:0]       sq_z_p;
    flags_t                       flags_in;
    flags_t                       flags_d;

    logic                         adv;
    logic [PRE_FINAL:0]           valid_reg;
    cvec_t                        lon_start_next;
    cvec_t                        lon_start_reg;
    logic [SQ_W-1:0]              sq_x_reg;
    logic [SQ_W-1:0]              sq_y_reg;
    logic [SQ_W-1:0]              sq_z_reg;
    logic [SQ_W-1:0]              sum_reg;

    cvec_t                        lon_vec [CORDIC_STAGES+1];
    cvec_t                        lat_vec [CORDIC_STAGES+1];
    logic [SQ_W-1:0]              rem_w   [COORD_BITS+1];
    logic [SQ_W-1:0]              root_w  [COORD_BITS+1];

    angle_t                       lon_ang;
    angle_t                       lon_wrap;
    angle_t                       lon_round;
    logic [LON_W-1:0]             lon_pre;
    logic [LON_W-1:0]             lon_d;
    angle_t                       lat_ang;
    angle_t                       lat_ang_d;
    angle_t                       lat_round;
    angle_t                       lat_clamp;
    logic [COORD_BITS-1:0]        mag_pre;
    logic [COORD_BITS-1:0]        mag_d;
    logic [LON_W-1:0]             lon_sel;
    logic [LAT_W-1:0]             lat_sel;
    logic [OUT_W-1:0]             out_next;
    logic [OUT_W-1:0]             out_reg;

    logic                         push;
    logic                         pop;
    logic [1:0]                   count_reg;
    logic [OUT_W-1:0]             fifo0_reg;
    logic [OUT_W-1:0]             fifo1_reg;

    // pipeline advances while the output buffer has room
    assign adv      = (count_reg != BUF_FULL);
    assign s_tready = adv;

    // unpack and prepare the item
    always_comb
    begin
        x_in    = s_tdata[COORD_BITS-1:0];
        y_in    = s_tdata[2*COORD_BITS-1:COORD_BITS];
        z_in    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        x_w     = word_t'(x_in);
        y_w     = word_t'(y_in);
        a_start = x_in[COORD_BITS-1] ? -x_w : x_w;
        b_start = x_in[COORD_BITS-1] ? -y_w : y_w;
        lon_start_next.a   = a_start <<< GUARD;
        lon_start_next.b   = b_start <<< GUARD;
        lon_start_next.ang = x_in[COORD_BITS-1] ? HALF_TURN : '0;
        zb_prod   = z_in * GAIN_Q30;
        zb_scaled = (word_t'(zb_prod) <<< ZB_LSH) >>> ZB_RSH;
        sq_x_p    = x_in * x_in;
        sq_y_p    = y_in * y_in;
        sq_z_p    = z_in * z_in;
        flags_in.zero_xy = (x_in == '0) && (y_in == '0);
        flags_in.z_neg   = z_in[COORD_BITS-1];
        flags_in.z_pos   = !z_in[COORD_BITS-1] && (z_in != '0);
    end

    // item valid bits, one per pipeline register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[PRE_FINAL-1:0], s_tvalid};
        end
    end

    // first stage: rotated start vector, squares; then the sum of squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lon_start_reg <= lon_start_next;
            sq_x_reg      <= sq_x_p;
            sq_y_reg      <= sq_y_p;
            sq_z_reg      <= sq_z_p;
            sum_reg       <= sq_x_reg + sq_y_reg + sq_z_reg;
        end
    end

    // longitude row
    assign lon_vec[0] = lon_start_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_lon
        c2s_cordic_cell #(.STAGE(i)) u_cell (
            .clk  (clk),
            .en   (adv),
            .vin  (lon_vec[i]),
            .vout (lon_vec[i+1])
        );
    end

    // z times gain, lined up with the end of the longitude row
    c2s_delay #(.WIDTH(DATA_W), .DEPTH(LON_END)) u_zb_dly (
        .clk (clk),
        .en  (adv),
        .d   (zb_scaled),
        .q   (zb_d)
    );

    // latitude row starts from the remaining radius and z
    always_comb
    begin
        lat_vec[0].a   = lon_vec[CORDIC_STAGES].a;
        lat_vec[0].b   = zb_d;
        lat_vec[0].ang = '0;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_lat
        c2s_cordic_cell #(.STAGE(i)) u_cell (
            .clk  (clk),
            .en   (adv),
            .vin  (lat_vec[i]),
            .vout (lat_vec[i+1])
        );
    end

    // longitude: wrap negative angles, round to 2^-16 degree, fold 360 to 0
    always_comb
    begin
        lon_ang   = lon_vec[CORDIC_STAGES].ang;
        lon_wrap  = lon_ang[ANG_W-1] ? lon_ang + FULL_TURN : lon_ang;
        lon_round = (lon_wrap + ANG_ROUND) >>> 8;
        lon_pre   = (lon_round >= LON_WRAP) ? LON_W'(lon_round - LON_WRAP)
                                            : LON_W'(lon_round);
    end

    c2s_delay #(.WIDTH(LON_W), .DEPTH(PRE_FINAL - LON_END)) u_lon_dly (
        .clk (clk),
        .en  (adv),
        .d   (lon_pre),
        .q   (lon_d)
    );

    assign lat_ang = lat_vec[CORDIC_STAGES].ang;

    if (PRE_FINAL > LAT_END)
    begin : g_lat_pad
        c2s_delay #(.WIDTH(ANG_W), .DEPTH(PRE_FINAL - LAT_END)) u_lat_dly (
            .clk (clk),
            .en  (adv),
            .d   (lat_ang),
            .q   (lat_ang_d)
        );
    end
    else
    begin : g_lat_direct
        assign lat_ang_d = lat_ang;
    end

    // square-root row
    assign rem_w[0]  = sum_reg;
    assign root_w[0] = '0;

    for (genvar j = 0; j < COORD_BITS; j++)
    begin : g_sqrt
        c2s_sqrt_cell #(.SQ_W(SQ_W), .STEP(j)) u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (rem_w[j]),
            .root_in  (root_w[j]),
            .rem_out  (rem_w[j+1]),
            .root_out (root_w[j+1])
        );
    end

    // round to nearest: bump when the remainder exceeds the root
    assign mag_pre = root_w[COORD_BITS][COORD_BITS-1:0]
                   + COORD_BITS'(rem_w[COORD_BITS] > root_w[COORD_BITS]);

    if (PRE_FINAL > SQ_END)
    begin : g_mag_pad
        c2s_delay #(.WIDTH(COORD_BITS), .DEPTH(PRE_FINAL - SQ_END)) u_mag_dly (
            .clk (clk),
            .en  (adv),
            .d   (mag_pre),
            .q   (mag_d)
        );
    end
    else
    begin : g_mag_direct
        assign mag_d = mag_pre;
    end

    c2s_delay #(.WIDTH($bits(flags_t)), .DEPTH(PRE_FINAL)) u_flag_dly (
        .clk (clk),
        .en  (adv),
        .d   (flags_in),
        .q   (flags_d)
    );

    // final stage: latitude rounding and clamp, points on the pole axis
    always_comb
    begin
        lat_round = (lat_ang_d + ANG_ROUND) >>> 8;
        priority if (lat_round > LAT_LIMIT)
        begin
            lat_clamp = LAT_LIMIT;
        end
        else if (lat_round < -LAT_LIMIT)
        begin
            lat_clamp = -LAT_LIMIT;
        end
        else
        begin
            lat_clamp = lat_round;
        end
        if (flags_d.zero_xy)
        begin
            lon_sel = '0;
            if (flags_d.z_pos)
            begin
                lat_sel = LAT_W'(LAT_LIMIT);
            end
            else if (flags_d.z_neg)
            begin
                lat_sel = LAT_W'(-LAT_LIMIT);
            end
            else
            begin
                lat_sel = '0;
            end
        end
        else
        begin
            lon_sel = lon_d;
            lat_sel = LAT_W'(lat_clamp);
        end
        out_next = {lat_sel, lon_sel, mag_d};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    // two-entry output buffer
    assign push = adv && valid_reg[PRE_FINAL];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == '0)
                begin
                    fifo0_reg <= out_reg;
                end
                else
                begin
                    fifo1_reg <= out_reg;
                end
            end
            2'b01:
            begin
                fifo0_reg <= fifo1_reg;
            end
            2'b11:
            begin
                if (count_reg == BUF_FULL)
                begin
                    fifo0_reg <= fifo1_reg;
                    fifo1_reg <= out_reg;
                end
                else
                begin
                    fifo0_reg <= out_reg;
                end
            end
            default:
            begin
                fifo0_reg <= fifo0_reg;
            end
        endcase
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = M_DATA_W'(fifo0_reg);

endmodule

FILE: rtl/c2s_delay.sv
module c2s_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // shift line, moves with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

FILE: rtl/c2s_cordic_cell.sv
module c2s_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic            clk,
    input  logic            en,
    input  c2s_pkg::cvec_t  vin,
    output c2s_pkg::cvec_t  vout
);

    import c2s_pkg::*;

    localparam angle_t STEP_ANG = stage_angle(STAGE);

    word_t  a_in;
    word_t  b_in;
    word_t  da;
    word_t  db;
    angle_t ang_in;
    cvec_t  vec_next;
    cvec_t  vec_reg;

    // one vectoring micro-rotation, direction from the sign of b
    always_comb
    begin
        a_in   = vin.a;
        b_in   = vin.b;
        ang_in = vin.ang;
        da     = b_in >>> STAGE;
        db     = a_in >>> STAGE;
        if (!b_in[DATA_W-1])
        begin
            vec_next.a   = a_in + da;
            vec_next.b   = b_in - db;
            vec_next.ang = ang_in + STEP_ANG;
        end
        else
        begin
            vec_next.a   = a_in - da;
            vec_next.b   = b_in + db;
            vec_next.ang = ang_in - STEP_ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vout = vec_reg;

endmodule

FILE: rtl/c2s_sqrt_cell.sv
module c2s_sqrt_cell #(
    parameter int SQ_W = 48,
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            en,
    input  logic [SQ_W-1:0] rem_in,
    input  logic [SQ_W-1:0] root_in,
    output logic [SQ_W-1:0] rem_out,
    output logic [SQ_W-1:0] root_out
);

    localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * STEP);

    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] rem_next;
    logic [SQ_W-1:0] root_next;
    logic [SQ_W-1:0] rem_reg;
    logic [SQ_W-1:0] root_reg;

    // one result bit: subtract the trial value when it fits
    always_comb
    begin
        trial = {1'b0, root_in} + BIT;
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next  = rem_in - trial[SQ_W-1:0];
            root_next = (root_in >> 1) + BIT[SQ_W-1:0];
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

FILE: rtl/c2s_checker.sv
module c2s_checker #(
    parameter  int COORD_BITS = 24,
    localparam int M_DATA_W   = ((COORD_BITS + c2s_pkg::LON_W + c2s_pkg::LAT_W + 7) / 8) * 8
) (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    import c2s_pkg::*;

    localparam logic        [LON_W-1:0] LON_MAX = 25'd23592959;
    localparam logic signed [LAT_W-1:0] LAT_MAX = 24'sd5898240;
    localparam logic signed [LAT_W-1:0] LAT_MIN = -24'sd5898240;

    logic        [LON_W-1:0] lon_f;
    logic signed [LAT_W-1:0] lat_f;

    assign lon_f = m_tdata[COORD_BITS+LON_W-1:COORD_BITS];
    assign lat_f = m_tdata[COORD_BITS+LON_W+LAT_W-1:COORD_BITS+LON_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // input backpressure only with a result waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input not ready with no result waiting");

    // ready falls only after the receiver stalled
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input ready dropped without an output stall");

    // longitude wrapped below a full turn
    a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> lon_f <= LON_MAX)
        else $error("longitude out of range");

    // latitude within the poles
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (lat_f <= LAT_MAX) && (lat_f >= LAT_MIN))
        else $error("latitude out of range");

endmodule

bind cartesian_to_spherical c2s_checker #(.COORD_BITS(COORD_BITS)) u_c2s_checker (.*);
